/* rtl/ptt_pkg.sv */
// Shared types, constants and helpers for the primitive triangle tessellator.
// No dependencies; every other file of the block imports this package.
package ptt_pkg;

   // Output coordinate width (Q16.4) and internal coordinate width with headroom
   localparam int VW = 20;
   localparam int CW = 24;

   localparam int MAX_SECTIONS   = 32;
   localparam int TRIG_BITS      = 16;
   localparam int TRIG_SH        = 30 - TRIG_BITS;
   localparam int TW             = 20;
   localparam int CORDIC_STEPS   = 28;
   localparam int CORDIC_IW      = $clog2(CORDIC_STEPS);
   localparam int CORDIC_XW      = 33;
   localparam int CORDIC_ZW      = 32;
   localparam int CORDIC_GAIN    = 652032874;
   localparam int LEN_EXTRA_BITS = 8;

   // Shared multiplier operand and product widths
   localparam int MW = 24;
   localparam int PW = 2 * MW;

   // Squared length, square root and divider widths
   localparam int SQ_W      = 46;
   localparam int SQRT_IW   = 64;
   localparam int SQRT_RW   = SQRT_IW / 2;
   localparam int SQRT_CW   = $clog2(SQRT_RW);
   localparam int DIV_NW    = 48;
   localparam int DIV_DW    = 34;
   localparam int DIV_CW    = $clog2(DIV_NW);

   // Command kinds
   localparam logic [2:0] CMD_LINE    = 3'd0;
   localparam logic [2:0] CMD_CIRCLE  = 3'd1;
   localparam logic [2:0] CMD_RING    = 3'd2;
   localparam logic [2:0] CMD_RECT    = 3'd3;
   localparam logic [2:0] CMD_OUTLINE = 3'd4;

   typedef struct packed {
      logic [2:0]           req_type;
      logic signed [VW-1:0] ax;
      logic signed [VW-1:0] ay;
      logic signed [VW-1:0] bx;
      logic signed [VW-1:0] by;
      logic [15:0]          radius;
      logic [11:0]          thickness;
      logic [5:0]           sections;
      logic [31:0]          color_a;
      logic [31:0]          color_b;
   } ptt_req_type;

   typedef struct packed {
      logic signed [VW-1:0] x0;
      logic signed [VW-1:0] y0;
      logic signed [VW-1:0] x1;
      logic signed [VW-1:0] y1;
      logic signed [VW-1:0] x2;
      logic signed [VW-1:0] y2;
      logic [31:0]          c0;
      logic [31:0]          c1;
      logic [31:0]          c2;
      logic                 last;
   } ptt_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_O_SETUP,
      ST_L_SETUP,
      ST_L_SQX,
      ST_L_SQY,
      ST_L_SQ,
      ST_L_SQRT_GO,
      ST_L_SQRT_WAIT,
      ST_L_MX,
      ST_L_DX_GO,
      ST_L_DX_WAIT,
      ST_L_MY,
      ST_L_DY_GO,
      ST_L_DY_WAIT,
      ST_L_E0,
      ST_L_E1,
      ST_C_DIV_GO,
      ST_C_DIV_WAIT,
      ST_C_COR_GO,
      ST_C_COR_WAIT,
      ST_C_M0,
      ST_C_M1,
      ST_C_M2,
      ST_C_M3,
      ST_C_M4,
      ST_C_NEXT,
      ST_C_E0,
      ST_C_E1,
      ST_R_E0,
      ST_R_E1
   } ptt_state_type;

   // CORDIC arctangent table in units of 2^-32 turn
   function automatic logic [29:0] atan_turn(input logic [CORDIC_IW-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'd536870912;
         5'd1:    v = 30'd316933406;
         5'd2:    v = 30'd167458907;
         5'd3:    v = 30'd85004756;
         5'd4:    v = 30'd42667331;
         5'd5:    v = 30'd21354465;
         5'd6:    v = 30'd10679838;
         5'd7:    v = 30'd5340245;
         5'd8:    v = 30'd2670163;
         5'd9:    v = 30'd1335087;
         5'd10:   v = 30'd667544;
         5'd11:   v = 30'd333772;
         5'd12:   v = 30'd166886;
         5'd13:   v = 30'd83443;
         5'd14:   v = 30'd41722;
         5'd15:   v = 30'd20861;
         5'd16:   v = 30'd10430;
         5'd17:   v = 30'd5215;
         5'd18:   v = 30'd2608;
         5'd19:   v = 30'd1304;
         5'd20:   v = 30'd652;
         5'd21:   v = 30'd326;
         5'd22:   v = 30'd163;
         5'd23:   v = 30'd81;
         5'd24:   v = 30'd41;
         5'd25:   v = 30'd20;
         5'd26:   v = 30'd10;
         5'd27:   v = 30'd5;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // Clamp an internal coordinate to the Q16.4 output range
   function automatic logic signed [VW-1:0] sat_coord(input logic signed [CW-1:0] v);
      logic signed [VW-1:0] r;
      if (v > CW'(signed'({1'b0, {(VW-1){1'b1}}}))) begin
         r = {1'b0, {(VW-1){1'b1}}};
      end else if (v < -CW'(signed'({1'b0, {(VW-1){1'b1}}})) - CW'(1)) begin
         r = {1'b1, {(VW-1){1'b0}}};
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/primitive_triangle_tessellator.sv */
// Top level of the primitive triangle tessellator: command sequencer, shared multiplier.
// Depends on ptt_pkg, ptt_div, ptt_sqrt and ptt_cordic.
//
// One draw command is taken when start is high and busy is low; busy then stays high
// until the final triangle has been issued. Triangles leave one per rsp_valid pulse,
// each for a single cycle, and cannot be held off. The work of a thick line lies in
// the square root and the two divisions for the displacement; an outlined rectangle
// is four such lines. A circle or ring takes, for each of its sections + 1 points,
// an angle division, a 28-step CORDIC and four products on the shared multiplier.
// Unknown command kinds are dropped without results.
module primitive_triangle_tessellator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ptt_pkg::ptt_req_type req_data,
   output logic                 rsp_valid,
   output ptt_pkg::ptt_rsp_type rsp_data
);
   import ptt_pkg::*;

   ptt_state_type        state_ff, state_in;
   ptt_req_type          req_ff, req_in;
   logic [5:0]           secs_ff, secs_in;
   logic [5:0]           k_ff, k_in;
   logic [1:0]           idx_ff, idx_in;
   logic signed [CW-1:0] fx_ff, fx_in, fy_ff, fy_in, tx_ff, tx_in, ty_ff, ty_in;
   logic signed [CW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [CW-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [SQRT_RW-1:0]   len_ff, len_in;
   logic                 neg_ff, neg_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [31:0]          ang_ff, ang_in;
   logic signed [CW-1:0] nox_ff, nox_in, noy_ff, noy_in, nix_ff, nix_in, niy_ff, niy_in;
   logic signed [CW-1:0] pox_ff, pox_in, poy_ff, poy_in, pix_ff, pix_in, piy_ff, piy_in;
   ptt_rsp_type          rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic                 div_start, div_done;
   logic [DIV_NW-1:0]    div_num, div_q;
   logic [DIV_DW-1:0]    div_den;
   logic                 sqrt_start, sqrt_done;
   logic [SQRT_RW-1:0]   sqrt_root;
   logic                 cor_start, cor_done;
   logic signed [TW-1:0] co, si;

   logic signed [CW-1:0] ax_s, ay_s, x1_s, y1_s, h_s;
   logic [12:0]          h13;
   logic signed [16:0]   rad_s, rin_s;
   logic signed [MW-1:0] th_m;
   logic signed [PW-1:0] prod_abs, off_full;
   logic signed [CW-1:0] off, qv;
   logic signed [CW-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
   logic [31:0]          ct;
   logic [5:0]           secs_raw;

   // iterative units
   ptt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   ptt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({2'b00, sq_ff, 16'd0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   ptt_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (ang_ff),
      .done    (cor_done),
      .cos_val (co),
      .sin_val (si)
   );

   // command geometry
   always_comb begin
      ax_s     = CW'(req_ff.ax);
      ay_s     = CW'(req_ff.ay);
      x1_s     = ax_s + CW'(req_ff.bx);
      y1_s     = ay_s + CW'(req_ff.by);
      h13      = {1'b0, req_ff.thickness} + 13'd1;
      h_s      = CW'(signed'({1'b0, h13[12:1]}));
      rad_s    = signed'({1'b0, req_ff.radius});
      rin_s    = rad_s - signed'({5'd0, req_ff.thickness});
      th_m     = MW'(signed'({1'b0, req_ff.thickness}));
      prod_abs = prod_ff[PW-1] ? -prod_ff : prod_ff;
      off_full = prod_ff + PW'(1 << (TRIG_BITS - 1));
      off      = signed'(off_full[TRIG_BITS+CW-1:TRIG_BITS]);
      qv       = signed'(div_q[CW-1:0]);
      p0x      = fx_ff + ex_ff;
      p0y      = fy_ff + ey_ff;
      p1x      = tx_ff + ex_ff;
      p1y      = ty_ff + ey_ff;
      p2x      = tx_ff - ex_ff;
      p2y      = ty_ff - ey_ff;
      p3x      = fx_ff - ex_ff;
      p3y      = fy_ff - ey_ff;
      ct       = (req_ff.req_type == CMD_LINE) ? req_ff.color_b : req_ff.color_a;
      secs_raw = req_data.sections;
   end

   // shared multiplier, product registered
   assign prod_in = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  CMD_LINE:    state_in = ST_L_SETUP;
                  CMD_CIRCLE:  state_in = ST_C_DIV_GO;
                  CMD_RING:    state_in = ST_C_DIV_GO;
                  CMD_RECT:    state_in = ST_R_E0;
                  CMD_OUTLINE: state_in = ST_O_SETUP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_O_SETUP:     state_in = ST_L_SETUP;
         ST_L_SETUP:     state_in = ST_L_SQX;
         ST_L_SQX:       state_in = ST_L_SQY;
         ST_L_SQY:       state_in = ST_L_SQ;
         ST_L_SQ:        state_in = ST_L_SQRT_GO;
         ST_L_SQRT_GO:   state_in = ST_L_SQRT_WAIT;
         ST_L_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = (sqrt_root == '0) ? ST_L_E0 : ST_L_MX;
            end
         end
         ST_L_MX:        state_in = ST_L_DX_GO;
         ST_L_DX_GO:     state_in = ST_L_DX_WAIT;
         ST_L_DX_WAIT:   if (div_done) state_in = ST_L_MY;
         ST_L_MY:        state_in = ST_L_DY_GO;
         ST_L_DY_GO:     state_in = ST_L_DY_WAIT;
         ST_L_DY_WAIT:   if (div_done) state_in = ST_L_E0;
         ST_L_E0:        state_in = ST_L_E1;
         ST_L_E1: begin
            if (req_ff.req_type == CMD_OUTLINE && idx_ff != 2'd3) begin
               state_in = ST_O_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_C_DIV_GO:    state_in = ST_C_DIV_WAIT;
         ST_C_DIV_WAIT:  if (div_done) state_in = ST_C_COR_GO;
         ST_C_COR_GO:    state_in = ST_C_COR_WAIT;
         ST_C_COR_WAIT:  if (cor_done) state_in = ST_C_M0;
         ST_C_M0:        state_in = ST_C_M1;
         ST_C_M1:        state_in = ST_C_M2;
         ST_C_M2:        state_in = ST_C_M3;
         ST_C_M3:        state_in = ST_C_M4;
         ST_C_M4:        state_in = ST_C_NEXT;
         ST_C_NEXT:      state_in = (k_ff == 6'd0) ? ST_C_DIV_GO : ST_C_E0;
         ST_C_E0: begin
            if (req_ff.req_type == CMD_RING) begin
               state_in = ST_C_E1;
            end else begin
               state_in = (k_ff == secs_ff) ? ST_IDLE : ST_C_DIV_GO;
            end
         end
         ST_C_E1:        state_in = (k_ff == secs_ff) ? ST_IDLE : ST_C_DIV_GO;
         ST_R_E0:        state_in = ST_R_E1;
         ST_R_E1:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      secs_in      = secs_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      sq_in        = sq_ff;
      len_in       = len_ff;
      neg_in       = neg_ff;
      ang_in       = ang_ff;
      nox_in       = nox_ff;
      noy_in       = noy_ff;
      nix_in       = nix_ff;
      niy_in       = niy_ff;
      pox_in       = pox_ff;
      poy_in       = poy_ff;
      pix_in       = pix_ff;
      piy_in       = piy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      cor_start    = 1'b0;
      div_num      = {({DIV_NW-LEN_EXTRA_BITS{1'b0}} | prod_abs[DIV_NW-LEN_EXTRA_BITS-1:0]),
                      {LEN_EXTRA_BITS{1'b0}}} + DIV_NW'(len_ff);
      div_den      = DIV_DW'({len_ff, 1'b0});
      case (state_ff)
         ST_IDLE: begin
            req_in = req_data;
            idx_in = 2'd0;
            k_in   = 6'd0;
            fx_in  = CW'(req_data.ax);
            fy_in  = CW'(req_data.ay);
            tx_in  = CW'(req_data.bx);
            ty_in  = CW'(req_data.by);
            if (secs_raw == 6'd0) begin
               secs_in = 6'd1;
            end else if (secs_raw > 6'(MAX_SECTIONS)) begin
               secs_in = 6'(MAX_SECTIONS);
            end else begin
               secs_in = secs_raw;
            end
         end
         // ends of one side of the outline, each stretched by half the width
         ST_O_SETUP: begin
            case (idx_ff)
               2'd0: begin
                  fx_in = ax_s - h_s;
                  fy_in = ay_s;
                  tx_in = x1_s + h_s;
                  ty_in = ay_s;
               end
               2'd1: begin
                  fx_in = x1_s;
                  fy_in = ay_s - h_s;
                  tx_in = x1_s;
                  ty_in = y1_s + h_s;
               end
               2'd2: begin
                  fx_in = x1_s + h_s;
                  fy_in = y1_s;
                  tx_in = ax_s - h_s;
                  ty_in = y1_s;
               end
               default: begin
                  fx_in = ax_s;
                  fy_in = y1_s + h_s;
                  tx_in = ax_s;
                  ty_in = ay_s - h_s;
               end
            endcase
         end
         ST_L_SETUP: begin
            dx_in = tx_ff - fx_ff;
            dy_in = ty_ff - fy_ff;
         end
         ST_L_SQX: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         ST_L_SQY: begin
            sq_in = prod_ff[SQ_W-1:0];
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         ST_L_SQ: begin
            sq_in = sq_ff + prod_ff[SQ_W-1:0];
         end
         ST_L_SQRT_GO: begin
            sqrt_start = 1'b1;
         end
         ST_L_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_in = sqrt_root;
               ex_in  = '0;
               ey_in  = '0;
            end
         end
         // displacement x = round(dy*t*2^8 / 2L)
         ST_L_MX: begin
            mul_a = dy_ff;
            mul_b = th_m;
         end
         ST_L_DX_GO: begin
            neg_in    = prod_ff[PW-1];
            div_start = 1'b1;
         end
         ST_L_DX_WAIT: begin
            if (div_done) begin
               ex_in = neg_ff ? -qv : qv;
            end
         end
         // displacement y = -round(dx*t*2^8 / 2L)
         ST_L_MY: begin
            mul_a = dx_ff;
            mul_b = th_m;
         end
         ST_L_DY_GO: begin
            neg_in    = !prod_ff[PW-1];
            div_start = 1'b1;
         end
         ST_L_DY_WAIT: begin
            if (div_done) begin
               ey_in = neg_ff ? -qv : qv;
            end
         end
         ST_L_E0: begin
            rsp_valid_in = 1'b1;
            rsp_in.x0    = sat_coord(p0x);
            rsp_in.y0    = sat_coord(p0y);
            rsp_in.x1    = sat_coord(p1x);
            rsp_in.y1    = sat_coord(p1y);
            rsp_in.x2    = sat_coord(p2x);
            rsp_in.y2    = sat_coord(p2y);
            rsp_in.c0    = req_ff.color_a;
            rsp_in.c1    = ct;
            rsp_in.c2    = ct;
            rsp_in.last  = 1'b0;
         end
         ST_L_E1: begin
            rsp_valid_in = 1'b1;
            rsp_in.x0    = sat_coord(p2x);
            rsp_in.y0    = sat_coord(p2y);
            rsp_in.x1    = sat_coord(p3x);
            rsp_in.y1    = sat_coord(p3y);
            rsp_in.x2    = sat_coord(p0x);
            rsp_in.y2    = sat_coord(p0y);
            rsp_in.c0    = ct;
            rsp_in.c1    = req_ff.color_a;
            rsp_in.c2    = req_ff.color_a;
            rsp_in.last  = (req_ff.req_type == CMD_LINE) || (idx_ff == 2'd3);
            idx_in       = idx_ff + 2'd1;
         end
         // angle of point k = round(k * 2^32 / sections)
         ST_C_DIV_GO: begin
            div_num   = DIV_NW'({k_ff, 32'd0}) + DIV_NW'(secs_ff >> 1);
            div_den   = DIV_DW'(secs_ff);
            div_start = 1'b1;
         end
         ST_C_DIV_WAIT: begin
            if (div_done) begin
               ang_in = div_q[31:0];
            end
         end
         ST_C_COR_GO: begin
            cor_start = 1'b1;
         end
         // four radius-by-trig products, one per cycle
         ST_C_M0: begin
            mul_a = MW'(rad_s);
            mul_b = MW'(co);
         end
         ST_C_M1: begin
            nox_in = ax_s + off;
            mul_a  = MW'(rad_s);
            mul_b  = MW'(si);
         end
         ST_C_M2: begin
            noy_in = ay_s + off;
            mul_a  = MW'(rin_s);
            mul_b  = MW'(co);
         end
         ST_C_M3: begin
            nix_in = ax_s + off;
            mul_a  = MW'(rin_s);
            mul_b  = MW'(si);
         end
         ST_C_M4: begin
            niy_in = ay_s + off;
         end
         ST_C_NEXT: begin
            if (k_ff == 6'd0) begin
               pox_in = nox_ff;
               poy_in = noy_ff;
               pix_in = nix_ff;
               piy_in = niy_ff;
               k_in   = 6'd1;
            end
         end
         ST_C_E0: begin
            rsp_valid_in = 1'b1;
            rsp_in.x1    = sat_coord(pox_ff);
            rsp_in.y1    = sat_coord(poy_ff);
            rsp_in.x2    = sat_coord(nox_ff);
            rsp_in.y2    = sat_coord(noy_ff);
            rsp_in.c0    = req_ff.color_a;
            rsp_in.c1    = req_ff.color_a;
            rsp_in.c2    = req_ff.color_a;
            if (req_ff.req_type == CMD_RING) begin
               rsp_in.x0   = sat_coord(pix_ff);
               rsp_in.y0   = sat_coord(piy_ff);
               rsp_in.last = 1'b0;
            end else begin
               rsp_in.x0   = sat_coord(ax_s);
               rsp_in.y0   = sat_coord(ay_s);
               rsp_in.last = k_ff == secs_ff;
               pox_in      = nox_ff;
               poy_in      = noy_ff;
               k_in        = k_ff + 6'd1;
            end
         end
         ST_C_E1: begin
            rsp_valid_in = 1'b1;
            rsp_in.x0    = sat_coord(nox_ff);
            rsp_in.y0    = sat_coord(noy_ff);
            rsp_in.x1    = sat_coord(nix_ff);
            rsp_in.y1    = sat_coord(niy_ff);
            rsp_in.x2    = sat_coord(pix_ff);
            rsp_in.y2    = sat_coord(piy_ff);
            rsp_in.c0    = req_ff.color_a;
            rsp_in.c1    = req_ff.color_a;
            rsp_in.c2    = req_ff.color_a;
            rsp_in.last  = k_ff == secs_ff;
            pox_in       = nox_ff;
            poy_in       = noy_ff;
            pix_in       = nix_ff;
            piy_in       = niy_ff;
            k_in         = k_ff + 6'd1;
         end
         ST_R_E0: begin
            rsp_valid_in = 1'b1;
            rsp_in.x0    = sat_coord(ax_s);
            rsp_in.y0    = sat_coord(ay_s);
            rsp_in.x1    = sat_coord(x1_s);
            rsp_in.y1    = sat_coord(ay_s);
            rsp_in.x2    = sat_coord(x1_s);
            rsp_in.y2    = sat_coord(y1_s);
            rsp_in.c0    = req_ff.color_a;
            rsp_in.c1    = req_ff.color_a;
            rsp_in.c2    = req_ff.color_a;
            rsp_in.last  = 1'b0;
         end
         ST_R_E1: begin
            rsp_valid_in = 1'b1;
            rsp_in.x0    = sat_coord(x1_s);
            rsp_in.y0    = sat_coord(y1_s);
            rsp_in.x1    = sat_coord(ax_s);
            rsp_in.y1    = sat_coord(y1_s);
            rsp_in.x2    = sat_coord(ax_s);
            rsp_in.y2    = sat_coord(ay_s);
            rsp_in.c0    = req_ff.color_a;
            rsp_in.c1    = req_ff.color_a;
            rsp_in.c2    = req_ff.color_a;
            rsp_in.last  = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      secs_ff <= secs_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      sq_ff   <= sq_in;
      len_ff  <= len_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      ang_ff  <= ang_in;
      nox_ff  <= nox_in;
      noy_ff  <= noy_in;
      nix_ff  <= nix_in;
      niy_ff  <= niy_in;
      pox_ff  <= pox_in;
      poy_ff  <= poy_in;
      pix_ff  <= pix_in;
      piy_ff  <= piy_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a command's final item is never followed directly by another item
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("item directly after final item of a command");

   // a known command kind keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.req_type <= CMD_OUTLINE) |=> busy)
      else $error("accepted command did not start");

   // an unknown command kind is dropped
   a_drop_unknown: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.req_type > CMD_OUTLINE) |=> !busy)
      else $error("unknown command kind was not dropped");

   // items only come out of a running command
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("item issued while idle");

endmodule

/* rtl/ptt_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ptt_pkg for widths.
module ptt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ptt_pkg::DIV_NW-1:0] dividend,
   input  logic [ptt_pkg::DIV_DW-1:0] divisor,
   output logic                      done,
   output logic [ptt_pkg::DIV_NW-1:0] quotient
);
   import ptt_pkg::*;

   logic [DIV_NW-1:0] num_ff, num_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   rem_sh;
   logic              fits;

   // one restoring step
   always_comb begin
      rem_sh = {rem_ff, num_ff[DIV_NW-1]};
      fits   = rem_sh >= {1'b0, den_ff};
   end

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[DIV_NW-2:0], fits};
         rem_in = fits ? DIV_DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_DW-1:0];
         cnt_in = cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

/* rtl/ptt_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle (floor result).
// Depends on ptt_pkg for widths.
module ptt_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ptt_pkg::SQRT_IW-1:0] radicand,
   output logic                        done,
   output logic [ptt_pkg::SQRT_RW-1:0] root
);
   import ptt_pkg::*;

   logic [SQRT_IW-1:0] rad_ff, rad_in;
   logic [SQRT_RW-1:0] root_ff, root_in;
   logic [SQRT_RW+1:0] rem_ff, rem_in;
   logic [SQRT_CW-1:0] cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [SQRT_RW+3:0] rem_sh;
   logic [SQRT_RW+3:0] trial;
   logic               fits;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[SQRT_IW-1:SQRT_IW-2]};
      trial  = {2'b00, root_ff, 2'b01};
      fits   = rem_sh >= trial;
   end

   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = {rad_ff[SQRT_IW-3:0], 2'b00};
         root_in = {root_ff[SQRT_RW-2:0], fits};
         rem_in  = fits ? (SQRT_RW+2)'(rem_sh - trial) : rem_sh[SQRT_RW+1:0];
         cnt_in  = cnt_ff + SQRT_CW'(1);
         if (cnt_ff == SQRT_CW'(SQRT_RW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/ptt_cordic.sv */
// Iterative rotation CORDIC: cosine and sine of a 32-bit turn angle,
// one micro-rotation per cycle. Depends on ptt_pkg for widths and the table.
module ptt_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   angle,
   output logic                          done,
   output logic signed [ptt_pkg::TW-1:0] cos_val,
   output logic signed [ptt_pkg::TW-1:0] sin_val
);
   import ptt_pkg::*;

   logic signed [CORDIC_XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_ZW-1:0] z_ff, z_in;
   logic [CORDIC_IW-1:0]        i_ff, i_in;
   logic [1:0]                  quad_ff, quad_in;
   logic                        zero_ff, zero_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic signed [CORDIC_XW-1:0] xs, ys;
   logic signed [CORDIC_XW:0]   cc, ss, cc_r, ss_r;

   // shared shifter for the micro-rotation
   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      quad_in = quad_ff;
      zero_in = zero_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_XW'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = CORDIC_ZW'({2'b00, angle[29:0]});
         i_in    = '0;
         quad_in = angle[31:30];
         zero_in = angle == 32'd0;
         run_in  = angle != 32'd0;
         done_in = angle == 32'd0;
      end else if (run_ff) begin
         if (!z_ff[CORDIC_ZW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - CORDIC_ZW'(atan_turn(i_ff));
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + CORDIC_ZW'(atan_turn(i_ff));
         end
         i_in = i_ff + CORDIC_IW'(1);
         if (i_ff == CORDIC_IW'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // quadrant fold and rounding to TRIG_BITS fraction bits
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cc = (CORDIC_XW+1)'(x_ff);
            ss = (CORDIC_XW+1)'(y_ff);
         end
         2'd1: begin
            cc = -(CORDIC_XW+1)'(y_ff);
            ss = (CORDIC_XW+1)'(x_ff);
         end
         2'd2: begin
            cc = -(CORDIC_XW+1)'(x_ff);
            ss = -(CORDIC_XW+1)'(y_ff);
         end
         default: begin
            cc = (CORDIC_XW+1)'(y_ff);
            ss = -(CORDIC_XW+1)'(x_ff);
         end
      endcase
      cc_r = (cc + (CORDIC_XW+1)'(1 << (TRIG_SH - 1))) >>> TRIG_SH;
      ss_r = (ss + (CORDIC_XW+1)'(1 << (TRIG_SH - 1))) >>> TRIG_SH;
      if (zero_ff) begin
         cos_val = TW'(1 << TRIG_BITS);
         sin_val = '0;
      end else begin
         cos_val = cc_r[TW-1:0];
         sin_val = ss_r[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff    <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         i_ff    <= i_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;

endmodule
